>>> rtl/lavb_pkg.sv
// Shared types and constants for the look-at view basis unit.
// No dependencies; every other file in rtl but lavb_delay imports this package.
`default_nettype none
package lavb_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int BASIS_FRAC_BITS = 14;
  localparam int OUT_WIDTH       = BASIS_FRAC_BITS + 2;
  localparam int SCALE_BITS      = 30;
  localparam int SW              = SCALE_BITS + 1;
  localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
  localparam int CROSS_WIDTH     = 2 * SW + 1;
  localparam int PRE_LAT         = 3;
  localparam int CROSS_LAT       = 2;
  localparam int AXIS_LAT        = PRE_LAT + CROSS_LAT;

  typedef logic [2:0][SW-1:0]        svec_t;
  typedef logic [2:0][OUT_WIDTH-1:0] ovec_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] eye_x;
    logic signed [COORD_WIDTH-1:0] eye_y;
    logic signed [COORD_WIDTH-1:0] eye_z;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;
    logic signed [COORD_WIDTH-1:0] up_x;
    logic signed [COORD_WIDTH-1:0] up_y;
    logic signed [COORD_WIDTH-1:0] up_z;
  } vectors_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] right_x;
    logic signed [OUT_WIDTH-1:0] right_y;
    logic signed [OUT_WIDTH-1:0] right_z;
    logic signed [OUT_WIDTH-1:0] upaxis_x;
    logic signed [OUT_WIDTH-1:0] upaxis_y;
    logic signed [OUT_WIDTH-1:0] upaxis_z;
    logic signed [OUT_WIDTH-1:0] back_x;
    logic signed [OUT_WIDTH-1:0] back_y;
    logic signed [OUT_WIDTH-1:0] back_z;
    logic                        degenerate;
  } basis_t;

  typedef struct packed {
    logic                        valid;
    logic                        nz;
    logic [2:0]                  neg;
    logic [2:0][SCALE_BITS-1:0]  mag;
  } ncarry_t;

endpackage
`default_nettype wire

>>> rtl/look_at_view_basis_unit.sv
// Look-at view basis: back, right and up axes as signed Q2.14 from Q16.16 eye,
// target and up. Depends on lavb_pkg, lavb_prescale, lavb_cross, lavb_normalize, lavb_delay.
//
// A fully pipelined unit: one transfer can be started in every clock cycle and
// busy is always low. Each start gives exactly one result, with done high for one
// cycle. From start to done the data pass through the input register, then three
// prescalers of three stages and two cross products of two stages on the way to
// the up axis, then its normaliser of 51 stages (32 square-root stages and fifteen
// quotient stages make up most of them), and the output register. The receiver
// cannot stall the unit and need not.
`default_nettype none
module look_at_view_basis_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire lavb_pkg::vectors_t vectors,
  output logic                    done,
  output lavb_pkg::basis_t        basis
);
  import lavb_pkg::*;

  logic                                in_v;
  logic [2:0][DIFF_WIDTH-1:0]          diff;
  logic [2:0][COORD_WIDTH-1:0]         upv;
  logic                                zs_v, zs_nz, up_v, up_nz;
  svec_t                               zs, ups, zs_d, xs, ys;
  logic                                x1_v, xs_v, xs_nz, y1_v, ys_v, ys_nz;
  logic [2:0][CROSS_WIDTH-1:0]         x1, y1;
  logic                                bk_v, bk_nz, rt_v, rt_nz, ua_v, ua_nz;
  ovec_t                               bk, rt, ua, bk_d, rt_d;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    diff[0] <= $signed({vectors.eye_x[COORD_WIDTH-1], vectors.eye_x})
             - $signed({vectors.target_x[COORD_WIDTH-1], vectors.target_x});
    diff[1] <= $signed({vectors.eye_y[COORD_WIDTH-1], vectors.eye_y})
             - $signed({vectors.target_y[COORD_WIDTH-1], vectors.target_y});
    diff[2] <= $signed({vectors.eye_z[COORD_WIDTH-1], vectors.eye_z})
             - $signed({vectors.target_z[COORD_WIDTH-1], vectors.target_z});
    upv[0]  <= vectors.up_x;
    upv[1]  <= vectors.up_y;
    upv[2]  <= vectors.up_z;
  end

  lavb_prescale #(.IW(DIFF_WIDTH)) u_pre_z (
    .clk(clk), .rst(rst), .in_valid(in_v), .in_vec(diff),
    .out_valid(zs_v), .out_nz(zs_nz), .out_vec(zs)
  );

  lavb_prescale #(.IW(COORD_WIDTH)) u_pre_up (
    .clk(clk), .rst(rst), .in_valid(in_v), .in_vec(upv),
    .out_valid(up_v), .out_nz(up_nz), .out_vec(ups)
  );

  lavb_normalize u_norm_back (
    .clk(clk), .rst(rst), .in_valid(zs_v), .in_nz(zs_nz), .in_vec(zs),
    .out_valid(bk_v), .out_nz(bk_nz), .out_vec(bk)
  );

  // Right axis: up x back. A zero up vector simply gives a zero cross product.
  lavb_cross u_cross_x (
    .clk(clk), .rst(rst), .in_valid(up_v && up_nz || zs_v), .a(ups), .b(zs),
    .out_valid(x1_v), .out_vec(x1)
  );

  lavb_prescale #(.IW(CROSS_WIDTH)) u_pre_x (
    .clk(clk), .rst(rst), .in_valid(x1_v), .in_vec(x1),
    .out_valid(xs_v), .out_nz(xs_nz), .out_vec(xs)
  );

  lavb_normalize u_norm_right (
    .clk(clk), .rst(rst), .in_valid(xs_v), .in_nz(xs_nz), .in_vec(xs),
    .out_valid(rt_v), .out_nz(rt_nz), .out_vec(rt)
  );

  lavb_delay #(.W(3 * SW), .N(AXIS_LAT)) u_dly_zs (
    .clk(clk), .d(zs), .q(zs_d)
  );

  lavb_cross u_cross_y (
    .clk(clk), .rst(rst), .in_valid(xs_v), .a(zs_d), .b(xs),
    .out_valid(y1_v), .out_vec(y1)
  );

  lavb_prescale #(.IW(CROSS_WIDTH)) u_pre_y (
    .clk(clk), .rst(rst), .in_valid(y1_v), .in_vec(y1),
    .out_valid(ys_v), .out_nz(ys_nz), .out_vec(ys)
  );

  lavb_normalize u_norm_upaxis (
    .clk(clk), .rst(rst), .in_valid(ys_v), .in_nz(ys_nz), .in_vec(ys),
    .out_valid(ua_v), .out_nz(ua_nz), .out_vec(ua)
  );

  lavb_delay #(.W(3 * OUT_WIDTH), .N(2 * AXIS_LAT)) u_dly_back (
    .clk(clk), .d(bk), .q(bk_d)
  );

  lavb_delay #(.W(3 * OUT_WIDTH), .N(AXIS_LAT)) u_dly_right (
    .clk(clk), .d(rt), .q(rt_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ua_v;
    end
  end

  // A zero view axis or right axis always forces a zero up axis, so the last
  // normaliser's flag covers every degenerate case.
  always_ff @(posedge clk) begin
    basis.right_x    <= rt_d[0];
    basis.right_y    <= rt_d[1];
    basis.right_z    <= rt_d[2];
    basis.upaxis_x   <= ua[0];
    basis.upaxis_y   <= ua[1];
    basis.upaxis_z   <= ua[2];
    basis.back_x     <= bk_d[0];
    basis.back_y     <= bk_d[1];
    basis.back_z     <= bk_d[2];
    basis.degenerate <= !ua_nz;
  end
endmodule
`default_nettype wire

>>> rtl/lavb_delay.sv
// Fixed-length register delay line used to keep side data aligned.
// Depends on nothing but its parameters.
`default_nettype none
module lavb_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    line[0] <= d;
    for (int i = 1; i < N; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign q = line[N-1];
endmodule
`default_nettype wire

>>> rtl/lavb_prescale.sv
// Three-stage prescaler: scales a signed vector so its largest magnitude lies in
// [2^29, 2^30), truncating magnitudes. Depends on lavb_pkg.
`default_nettype none
module lavb_prescale #(
  parameter int IW = 33
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [2:0][IW-1:0] in_vec,
  output logic                    out_valid,
  output logic                    out_nz,
  output lavb_pkg::svec_t         out_vec
);
  import lavb_pkg::*;

  localparam int BW = $clog2(IW + 1);

  logic [2:0][IW-1:0] mag_c;
  logic [2:0][IW-1:0] mag1, mag2;
  logic [2:0]         neg1, neg2;
  logic [IW-1:0]      or1, or2;
  logic               v1, v2;
  logic [BW-1:0]      bits_c, bits2;
  svec_t              vec_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][IW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
  end

  // Bit length of the OR of the magnitudes equals that of the largest one.
  always_comb begin
    bits_c = '0;
    for (int j = 0; j < IW; j++) begin
      if (or1[j]) begin
        bits_c = BW'(j + 1);
      end
    end
  end

  always_comb begin
    logic [SCALE_BITS-1:0] m;
    logic [SW-1:0]         mw;
    for (int i = 0; i < 3; i++) begin
      if (bits2 > BW'(SCALE_BITS)) begin
        m = SCALE_BITS'(mag2[i] >> (bits2 - BW'(SCALE_BITS)));
      end else begin
        m = mag2[i][SCALE_BITS-1:0] << (BW'(SCALE_BITS) - bits2);
      end
      mw = {1'b0, m};
      vec_c[i] = neg2[i] ? (~mw + 1'b1) : mw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    mag1    <= mag_c;
    neg1    <= {in_vec[2][IW-1], in_vec[1][IW-1], in_vec[0][IW-1]};
    or1     <= mag_c[0] | mag_c[1] | mag_c[2];
    mag2    <= mag1;
    neg2    <= neg1;
    or2     <= or1;
    bits2   <= bits_c;
    out_vec <= vec_c;
    out_nz  <= |or2;
  end
endmodule
`default_nettype wire

>>> rtl/lavb_cross.sv
// Two-stage integer cross product a x b of prescaled vectors: products, then
// differences. Depends on lavb_pkg.
`default_nettype none
module lavb_cross (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire lavb_pkg::svec_t                      a,
  input  wire lavb_pkg::svec_t                      b,
  output logic                                      out_valid,
  output logic [2:0][lavb_pkg::CROSS_WIDTH-1:0]     out_vec
);
  import lavb_pkg::*;

  localparam int PW = 2 * SW;

  logic signed [PW-1:0] p [6];
  logic                 v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p[0] <= $signed(a[1]) * $signed(b[2]);
    p[1] <= $signed(a[2]) * $signed(b[1]);
    p[2] <= $signed(a[2]) * $signed(b[0]);
    p[3] <= $signed(a[0]) * $signed(b[2]);
    p[4] <= $signed(a[0]) * $signed(b[1]);
    p[5] <= $signed(a[1]) * $signed(b[0]);
    for (int i = 0; i < 3; i++) begin
      out_vec[i] <= $signed({p[2*i][PW-1], p[2*i]}) - $signed({p[2*i+1][PW-1], p[2*i+1]});
    end
  end
endmodule
`default_nettype wire

>>> rtl/lavb_normalize.sv
// Pipelined normaliser: squares and sum, one integer square-root bit per stage,
// then one rounded quotient bit per stage for all three lanes. Depends on lavb_pkg.
`default_nettype none
module lavb_normalize (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_nz,
  input  wire lavb_pkg::svec_t in_vec,
  output logic                 out_valid,
  output logic                 out_nz,
  output lavb_pkg::ovec_t      out_vec
);
  import lavb_pkg::*;

  localparam int F    = BASIS_FRAC_BITS;
  localparam int SQW  = 2 * SCALE_BITS;
  localparam int ISQ  = 32;
  localparam int NW   = F + 33;
  localparam int QW   = F + 1;

  ncarry_t               c_in, ca, cb, cn;
  ncarry_t               ci [ISQ+1];
  ncarry_t               cd [QW+1];
  logic [2:0][SQW-1:0]   sq;
  logic [63:0]           sum;
  logic [63:0]           nr [ISQ+1];
  logic [63:0]           rs [ISQ+1];
  logic [2:0][NW-1:0]    rem [QW+1];
  logic [2:0][QW-1:0]    qb [QW+1];
  logic [NW-1:0]         den [QW+1];

  always_comb begin
    c_in.valid = in_valid;
    c_in.nz    = in_nz;
    for (int i = 0; i < 3; i++) begin
      c_in.neg[i] = in_vec[i][SW-1];
      c_in.mag[i] = SCALE_BITS'(in_vec[i][SW-1] ? (~in_vec[i] + 1'b1) : in_vec[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ca.valid <= 1'b0;
      cb.valid <= 1'b0;
    end else begin
      ca.valid <= c_in.valid;
      cb.valid <= ca.valid;
    end
  end

  always_ff @(posedge clk) begin
    ca.nz  <= c_in.nz;
    ca.neg <= c_in.neg;
    ca.mag <= c_in.mag;
    cb.nz  <= ca.nz;
    cb.neg <= ca.neg;
    cb.mag <= ca.mag;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= c_in.mag[i] * c_in.mag[i];
    end
    sum <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
  end

  assign ci[0] = cb;
  assign nr[0] = sum;
  assign rs[0] = '0;

  for (genvar k = 0; k < ISQ; k++) begin : g_isqrt
    localparam logic [63:0] BITK = 64'd1 << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (rst) begin
        ci[k+1].valid <= 1'b0;
      end else begin
        ci[k+1].valid <= ci[k].valid;
      end
    end
    always_ff @(posedge clk) begin
      ci[k+1].nz  <= ci[k].nz;
      ci[k+1].neg <= ci[k].neg;
      ci[k+1].mag <= ci[k].mag;
      if (nr[k] >= rs[k] + BITK) begin
        nr[k+1] <= nr[k] - (rs[k] + BITK);
        rs[k+1] <= (rs[k] >> 1) + BITK;
      end else begin
        nr[k+1] <= nr[k];
        rs[k+1] <= rs[k] >> 1;
      end
    end
  end

  // Numerator |s| * 2^(F+1) + L over divisor 2L gives the rounded quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      cn.valid <= 1'b0;
    end else begin
      cn.valid <= ci[ISQ].valid;
    end
  end

  always_ff @(posedge clk) begin
    cn.nz  <= ci[ISQ].nz;
    cn.neg <= ci[ISQ].neg;
    cn.mag <= ci[ISQ].mag;
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= (NW'(ci[ISQ].mag[i]) << (F + 1)) + NW'(rs[ISQ][31:0]);
    end
    den[0] <= NW'({rs[ISQ][31:0], 1'b0});
  end

  assign cd[0] = cn;
  assign qb[0] = '0;

  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int J = QW - 1 - t;
    always_ff @(posedge clk) begin
      if (rst) begin
        cd[t+1].valid <= 1'b0;
      end else begin
        cd[t+1].valid <= cd[t].valid;
      end
    end
    always_ff @(posedge clk) begin
      cd[t+1].nz  <= cd[t].nz;
      cd[t+1].neg <= cd[t].neg;
      cd[t+1].mag <= cd[t].mag;
      den[t+1]    <= den[t];
      for (int i = 0; i < 3; i++) begin
        if (rem[t][i] >= (den[t] << J)) begin
          rem[t+1][i] <= rem[t][i] - (den[t] << J);
          qb[t+1][i]  <= qb[t][i] | QW'(1 << J);
        end else begin
          rem[t+1][i] <= rem[t][i];
          qb[t+1][i]  <= qb[t][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cd[QW].valid;
    end
  end

  // A zero-length vector gives zeros rather than the meaningless quotient.
  always_ff @(posedge clk) begin
    logic [OUT_WIDTH-1:0] qq;
    out_nz <= cd[QW].nz;
    for (int i = 0; i < 3; i++) begin
      qq = {1'b0, qb[QW][i]};
      if (!cd[QW].nz) begin
        out_vec[i] <= '0;
      end else if (cd[QW].neg[i]) begin
        out_vec[i] <= ~qq + 1'b1;
      end else begin
        out_vec[i] <= qq;
      end
    end
  end
endmodule
`default_nettype wire
